// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the ready queue RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check with asynchronous active-low reset masking.
`define APRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds while in reset.
`define APRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define APRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define APRQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/aprq_pkg.sv =====
// Package for the aging priority ready queue: field widths, codes and payload types.
// No dependencies; imported by the compare/age unit, the top level and the bench.
package aprq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CMD_W   = 2;
  localparam int TASK_W  = 4;
  localparam int PRIO_W  = 8;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 5;
  localparam logic [PRIO_W-1:0] AGE_FLOOR = PRIO_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
    logic              hold_dispatch;
  } aprq_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              dispatch_valid;
    logic [TASK_W-1:0] dispatched_task;
    logic [CNT_W-1:0]  queue_count;
  } aprq_out_t;

  // One queue slot as held in the slot RAM
  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Operands the sequencer hands to the compare/age unit
  typedef struct packed {
    logic [TASK_W-1:0] key_task;
    logic [PRIO_W-1:0] key_prio;
    logic              skip_on_match;
  } alu_op_t;

  typedef struct packed {
    logic              task_eq;
    logic              prio_le;
    logic [PRIO_W-1:0] aged_prio;
  } alu_res_t;

endpackage

// ===== rtl/aprq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the queue slots.
module aprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/aprq_alu.sv =====
// Shared compare and age unit: task match, priority order test and aged priority.
// Depends on aprq_pkg.
module aprq_alu (
  input  aprq_pkg::entry_t   entry_i,
  input  aprq_pkg::alu_op_t  op_i,
  output aprq_pkg::alu_res_t res_o
);
  import aprq_pkg::*;

  logic eq;

  // Compare the slot against the key
  assign eq = (entry_i.task_id == op_i.key_task);

  // Report the compares; age by one above the floor, leave the running task alone
  always_comb begin
    res_o.task_eq   = eq;
    res_o.prio_le   = (entry_i.prio <= op_i.key_prio);
    res_o.aged_prio = entry_i.prio;
    if (!(op_i.skip_on_match && eq) && (entry_i.prio > AGE_FLOOR)) begin
      res_o.aged_prio = entry_i.prio - PRIO_W'(1);
    end
  end

endmodule

// ===== rtl/aging_priority_ready_queue_top.sv =====
// Top level of the aging priority ready queue: command sequencer and result register.
// Depends on aprq_pkg, aprq_ram, aprq_alu and assert_macros.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (aprq_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (aprq_out_t)
//
// One command at a time; each slot visit is a RAM read state, then a use state.
// Insert checks the slots for a duplicate and position P, shifts the slots from P on
// back, then writes; tick ages each slot; clear and unused codes go to the result.
// Reset empties the queue and clears the running task; slot contents need no clearing.
// A result waiting on out_ready_i holds the sequencer in its final state.
module aging_priority_ready_queue_top #(
  parameter int QUEUE_DEPTH = aprq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  aprq_pkg::aprq_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output aprq_pkg::aprq_out_t out_data_o
);
  import aprq_pkg::*;
`include "assert_macros.svh"

  localparam int AW = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DUP_RD,
    S_DUP_CHK,
    S_SHF_RD,
    S_SHF_WR,
    S_INS_WR,
    S_TICK_RD,
    S_TICK_WR,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  aprq_in_t          req_q, req_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [TASK_W-1:0] run_task_q, run_task_d;
  logic              run_valid_q, run_valid_d;
  status_e           stat_q, stat_d;
  logic              dv_q, dv_d;
  logic [TASK_W-1:0] disp_q, disp_d;
  logic              out_valid_q, out_valid_d;
  aprq_out_t         out_data_q, out_data_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  entry_t            mem_wdata;
  entry_t            mem_rdata;
  alu_op_t           alu_op;
  alu_res_t          alu_res;

  logic              last;
  logic              pop;
  logic [CNT_W-1:0]  pos_nx;
  logic [TASK_W-1:0] disp_nx;

  logic              in_xfer;
  logic              scan_chk;
  logic              refused_pop;

  aprq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Key is the new task on insert, the running task on tick
  assign alu_op.key_task      = (req_q.command == CMD_TICK) ? run_task_q : req_q.task_id;
  assign alu_op.key_prio      = req_q.priority_req;
  assign alu_op.skip_on_match = run_valid_q;

  aprq_alu u_alu (
    .entry_i (mem_rdata),
    .op_i    (alu_op),
    .res_o   (alu_res)
  );

  assign last = (idx_q == (count_q - CNT_W'(1)));
  assign pop  = !req_q.hold_dispatch;

  // Sequence one command over the slots
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    count_d     = count_q;
    run_task_d  = run_task_q;
    run_valid_d = run_valid_q;
    stat_d      = stat_q;
    dv_d        = dv_q;
    disp_d      = disp_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = AW'(idx_q);
    mem_wdata   = mem_rdata;
    mem_raddr   = AW'(idx_q);
    pos_nx      = pos_q;
    disp_nx     = disp_q;

    // Drop the result once transferred
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_data_i;
          idx_d  = '0;
          pos_d  = '0;
          stat_d = ST_DONE;
          dv_d   = 1'b0;
          disp_d = '0;
          case (in_data_i.command)
            CMD_INSERT: state_d = (count_q == '0) ? S_INS_WR : S_DUP_RD;
            CMD_TICK:   state_d = (count_q == '0) ? S_DONE : S_TICK_RD;
            CMD_CLEAR: begin
              count_d = '0;
              state_d = S_DONE;
            end
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_DUP_RD: begin
        state_d = S_DUP_CHK;
      end
      S_DUP_CHK: begin
        if (alu_res.task_eq) begin
          stat_d  = ST_DUP;
          state_d = S_DONE;
        end else begin
          // Insert after the last slot not above the new priority
          pos_nx = alu_res.prio_le ? (idx_q + CNT_W'(1)) : pos_q;
          pos_d  = pos_nx;
          if (last) begin
            if (int'(count_q) >= QUEUE_DEPTH) begin
              stat_d  = ST_FULL;
              state_d = S_DONE;
            end else if (pos_nx == count_q) begin
              state_d = S_INS_WR;
            end else begin
              idx_d   = count_q;
              state_d = S_SHF_RD;
            end
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = S_DUP_RD;
          end
        end
      end
      S_SHF_RD: begin
        mem_raddr = AW'(idx_q - CNT_W'(1));
        state_d   = S_SHF_WR;
      end
      S_SHF_WR: begin
        // Move one slot towards the tail
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_q);
        mem_wdata = mem_rdata;
        idx_d     = idx_q - CNT_W'(1);
        state_d   = ((idx_q - CNT_W'(1)) == pos_q) ? S_INS_WR : S_SHF_RD;
      end
      S_INS_WR: begin
        mem_we            = 1'b1;
        mem_waddr         = AW'(pos_q);
        mem_wdata.task_id = req_q.task_id;
        mem_wdata.prio    = req_q.priority_req;
        count_d           = count_q + CNT_W'(1);
        stat_d            = ST_DONE;
        state_d           = S_DONE;
      end
      S_TICK_RD: begin
        state_d = S_TICK_WR;
      end
      S_TICK_WR: begin
        // Age the slot and, when popping, move it one towards the front
        if (pop && (idx_q == '0)) begin
          disp_nx = mem_rdata.task_id;
          disp_d  = disp_nx;
        end else begin
          mem_we            = 1'b1;
          mem_waddr         = pop ? AW'(idx_q - CNT_W'(1)) : AW'(idx_q);
          mem_wdata.task_id = mem_rdata.task_id;
          mem_wdata.prio    = alu_res.aged_prio;
        end
        if (last) begin
          if (pop) begin
            count_d     = count_q - CNT_W'(1);
            run_task_d  = disp_nx;
            run_valid_d = 1'b1;
            dv_d        = 1'b1;
          end
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_TICK_RD;
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                = 1'b1;
          out_data_d.status          = stat_q;
          out_data_d.dispatch_valid  = dv_q;
          out_data_d.dispatched_task = disp_q;
          out_data_d.queue_count     = count_q;
          state_d                    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, queue bookkeeping and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      run_task_q  <= '0;
      run_valid_q <= 1'b0;
      stat_q      <= ST_DONE;
      dv_q        <= 1'b0;
      disp_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      run_task_q  <= run_task_d;
      run_valid_q <= run_valid_d;
      stat_q      <= stat_d;
      dv_q        <= dv_d;
      disp_q      <= disp_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Terms for the checks below
  assign in_xfer     = in_valid_i && in_ready_o;
  assign scan_chk    = (state_q == S_DUP_CHK) || (state_q == S_TICK_WR);
  assign refused_pop = out_valid_o && (out_data_o.status != ST_DONE) &&
                       out_data_o.dispatch_valid;

  `APRQ_ASSERT_ALWAYS(a_count_le_depth, clk_i, int'(count_q) <= QUEUE_DEPTH, "count above depth")
  `APRQ_ASSERT(a_busy_after_in, clk_i, rst_ni, in_xfer |=> !in_ready_o, "ready after transfer")
  `APRQ_ASSERT(a_idx_in_range, clk_i, rst_ni, scan_chk |-> idx_q < count_q, "index past count")
  `APRQ_ASSERT(a_refused_no_pop, clk_i, rst_ni, !refused_pop, "refused insert reports a dispatch")

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the aging priority ready queue top level.
// Needs aprq_pkg and aging_priority_ready_queue_top; predicts every outcome in a scoreboard class.
module testbench;
  import aprq_pkg::*;

  localparam int                DEPTH       = QUEUE_DEPTH_DEF;
  localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
  localparam int                ITEM_TARGET = 850;
  localparam int                SETTLE_CYC  = 80;
  localparam int                CYCLE_LIMIT = 500000;
  localparam int                MAX_SHOWN   = 10;
  localparam int                IN_W        = $bits(aprq_in_t);

  // Shadow of the ready queue; holds the outcomes still owed by the block
  class sched_outcome_board;
    logic [TASK_W-1:0] slot_id   [DEPTH];
    logic [PRIO_W-1:0] slot_prio [DEPTH];
    int                slot_count;
    logic [TASK_W-1:0] cur_task;
    bit                cur_valid;
    aprq_out_t         owed [$];
    int unsigned       mismatches;

    function new();
      slot_count = 0;
      cur_task   = '0;
      cur_valid  = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Sorted insert behind equals; duplicates are refused before the full check
    function logic [STAT_W-1:0] enqueue(logic [TASK_W-1:0] id, logic [PRIO_W-1:0] prio);
      int pos;
      for (int i = 0; i < slot_count; i++)
        if (slot_id[i] == id) return ST_DUP;
      if (slot_count >= DEPTH) return ST_FULL;
      pos = slot_count;
      while (pos > 0 && prio < slot_prio[pos-1]) pos--;
      for (int i = slot_count; i > pos; i--) begin
        slot_id[i]   = slot_id[i-1];
        slot_prio[i] = slot_prio[i-1];
      end
      slot_id[pos]   = id;
      slot_prio[pos] = prio;
      slot_count++;
      return ST_DONE;
    endfunction

    // Advance the shadow by one command and work out the outcome it owes
    function aprq_out_t predict_step(aprq_in_t cmd);
      aprq_out_t res;
      res = '0;
      case (cmd.command)
        CMD_INSERT: res.status = enqueue(cmd.task_id, cmd.priority_req);
        CMD_TICK: begin
          // Age everything but the running task, never below the floor
          for (int i = 0; i < slot_count; i++) begin
            if (!(cur_valid && slot_id[i] == cur_task) && slot_prio[i] > AGE_FLOOR)
              slot_prio[i] = slot_prio[i] - 1'b1;
          end
          if (slot_count > 0 && !cmd.hold_dispatch) begin
            res.dispatch_valid  = 1'b1;
            res.dispatched_task = slot_id[0];
            cur_task  = slot_id[0];
            cur_valid = 1;
            for (int i = 1; i < slot_count; i++) begin
              slot_id[i-1]   = slot_id[i];
              slot_prio[i-1] = slot_prio[i];
            end
            slot_count--;
          end
        end
        CMD_CLEAR: slot_count = 0;
        default: ;
      endcase
      res.queue_count = CNT_W'(slot_count);
      return res;
    endfunction

    function void note_command(aprq_in_t cmd);
      owed.push_back(predict_step(cmd));
    endfunction

    function void flag(string what, logic [7:0] want, logic [7:0] got);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_outcome(aprq_out_t got);
      aprq_out_t want;
      if (owed.size() == 0) begin
        flag("unexpected result", 8'd0, 8'd1);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) flag("status", 8'(want.status), 8'(got.status));
      if (got.dispatch_valid !== want.dispatch_valid)
        flag("dispatch_valid", 8'(want.dispatch_valid), 8'(got.dispatch_valid));
      if (got.dispatched_task !== want.dispatched_task)
        flag("dispatched_task", 8'(want.dispatched_task), 8'(got.dispatched_task));
      if (got.queue_count !== want.queue_count)
        flag("queue_count", 8'(want.queue_count), 8'(got.queue_count));
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  aprq_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  aprq_out_t out_data_o;

  sched_outcome_board sb = new();
  int  cycles    = 0;
  int  sent      = 0;
  bit  tx_steady = 0;
  bit  rx_steady = 0;

  aging_priority_ready_queue_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Note each input transfer before checking the output transfer of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_command(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_outcome(out_data_o);
    end
  end

  // Give up on a hung block
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stall the result side at random, with stretches of steady acceptance
  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  function automatic logic [PRIO_W-1:0] pick_prio();
    case ($urandom_range(0, 7))
      0, 1:    return PRIO_W'($urandom_range(0, 3));
      2:       return '1;
      default: return PRIO_W'($urandom());
    endcase
  endfunction

  function automatic aprq_in_t make_cmd(logic [CMD_W-1:0] op, logic [TASK_W-1:0] id,
                                        logic [PRIO_W-1:0] prio, logic hold);
    aprq_in_t c;
    c.command       = op;
    c.task_id       = id;
    c.priority_req  = prio;
    c.hold_dispatch = hold;
    return c;
  endfunction

  function automatic aprq_in_t rand_tick(int hold_pct);
    return make_cmd(CMD_TICK, TASK_W'($urandom()), PRIO_W'($urandom()),
                    $urandom_range(0, 99) < hold_pct);
  endfunction

  // Offer one command after a random gap; leave valid high once it transfers
  task automatic send_item(aprq_in_t item);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent++;
  endtask

  // Hold off until every owed outcome has arrived
  task automatic wait_drained();
    while (sb.pending() > 0) @(negedge clk_i);
  endtask

  task automatic fill_queue();
    int order [DEPTH];
    int j, t;
    for (int i = 0; i < DEPTH; i++) order[i] = i;
    for (int i = DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < DEPTH; i++)
      send_item(make_cmd(CMD_INSERT, TASK_W'(order[i]), pick_prio(),
                         1'($urandom_range(0, 1))));
    // Inserts against a full queue, refused as duplicates since every task id is queued
    repeat (2)
      send_item(make_cmd(CMD_INSERT, TASK_W'($urandom()), pick_prio(),
                         1'($urandom_range(0, 1))));
  endtask

  task automatic directed_part();
    send_item(make_cmd(CMD_UNUSED, 4'd15, 8'd255, 1'b1));
    send_item(make_cmd(CMD_TICK,   4'd0,  8'd0,   1'b0));
    send_item(make_cmd(CMD_INSERT, 4'd0,  8'd255, 1'b0));
    send_item(make_cmd(CMD_INSERT, 4'd15, 8'd0,   1'b1));
    send_item(make_cmd(CMD_INSERT, 4'd5,  8'd1,   1'b0));
    send_item(make_cmd(CMD_INSERT, 4'd6,  8'd2,   1'b0));
    send_item(make_cmd(CMD_INSERT, 4'd7,  8'd2,   1'b0));
    send_item(make_cmd(CMD_INSERT, 4'd0,  8'd10,  1'b0));
    send_item(make_cmd(CMD_TICK,   4'd0,  8'd0,   1'b1));
    send_item(make_cmd(CMD_TICK,   4'd3,  8'd9,   1'b0));
    send_item(make_cmd(CMD_INSERT, 4'd15, 8'd128, 1'b0));
    send_item(make_cmd(CMD_TICK,   4'd0,  8'd0,   1'b1));
    send_item(make_cmd(CMD_TICK,   4'd0,  8'd0,   1'b0));
    send_item(make_cmd(CMD_INSERT, 4'd9,  8'd3,   1'b0));
    send_item(make_cmd(CMD_UNUSED, 4'd0,  8'd0,   1'b0));
    send_item(make_cmd(CMD_CLEAR,  4'd10, 8'd170, 1'b1));
    send_item(make_cmd(CMD_TICK,   4'd0,  8'd0,   1'b0));
    send_item(make_cmd(CMD_INSERT, 4'd10, 8'd85,  1'b1));
    send_item(make_cmd(CMD_TICK,   4'd0,  8'd0,   1'b0));
  endtask

  initial begin
    int  len;
    bit  paused;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_part();
    in_valid_i <= 1'b0;
    wait_drained();

    // Mostly well-formed bursts of inserts and ticks, with some noise
    fill_queue();
    paused = 0;
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) tx_steady = !tx_steady;
      if (!paused && sent >= ITEM_TARGET / 2) begin
        in_valid_i <= 1'b0;
        wait_drained();
        paused = 1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          len = $urandom_range(1, 12);
          repeat (len)
            send_item(make_cmd(CMD_INSERT, TASK_W'($urandom()), pick_prio(),
                               1'($urandom_range(0, 1))));
        end
        4, 5, 6: begin
          len = $urandom_range(1, 6);
          repeat (len) send_item(rand_tick(25));
        end
        7: fill_queue();
        8: begin
          len = $urandom_range(1, 5);
          repeat (len) send_item(aprq_in_t'(IN_W'($urandom())));
        end
        default: begin
          if ($urandom_range(0, 1) == 0)
            send_item(make_cmd(CMD_CLEAR, TASK_W'($urandom()), PRIO_W'($urandom()),
                               1'($urandom_range(0, 1))));
          else begin
            len = $urandom_range(8, 30);
            repeat (len) send_item(rand_tick(70));
          end
        end
      endcase
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (SETTLE_CYC) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
